[rtl/core/srvb_pkg.sv]
// ----------------------------------------------------------------------------
// srvb_pkg: shared types and constants for the comb/allpass reverb
// Widths, line counts, register indexes and reset values.
// ----------------------------------------------------------------------------
package srvb_pkg;

  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned WordWidth    = 24;
  localparam int unsigned PosWidth     = 12;
  localparam int unsigned LenWidth     = 13;
  localparam int unsigned LineDepth    = 4096;
  localparam int unsigned CombCount    = 4;
  localparam int unsigned AllpassCount = 2;
  localparam int unsigned LineCount    = CombCount + AllpassCount;
  localparam int unsigned LineWidth    = 3;
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgWidth     = 17;

  localparam int signed WordMax = 8388607;
  localparam int signed WordMin = -8388608;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_FEEDBACK = 8'd0,
    REG_MIX      = 8'd1,
    REG_COMB0    = 8'd2,
    REG_COMB1    = 8'd3,
    REG_COMB2    = 8'd4,
    REG_COMB3    = 8'd5,
    REG_AP0      = 8'd6,
    REG_AP1      = 8'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MIX,
    ST_DONE
  } state_e;

  function automatic logic [LenWidth-1:0] default_len(input logic [LineWidth-1:0] l);
    logic [LenWidth-1:0] r;
    case (l)
      3'd0:    r = 13'd1116;
      3'd1:    r = 13'd1188;
      3'd2:    r = 13'd1277;
      3'd3:    r = 13'd1356;
      3'd4:    r = 13'd556;
      3'd5:    r = 13'd441;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

  function automatic logic [LenWidth-1:0] fit_len(input logic [LenWidth-1:0] v);
    logic [LenWidth-1:0] r;
    if (v == '0) r = 13'd1;
    else if (v > LenWidth'(LineDepth)) r = LenWidth'(LineDepth);
    else r = v;
    return r;
  endfunction

  function automatic logic signed [WordWidth-1:0] sat_word(input logic signed [47:0] v);
    logic signed [WordWidth-1:0] r;
    if (v > 48'(WordMax)) r = WordWidth'(WordMax);
    else if (v < 48'(WordMin)) r = WordWidth'(WordMin);
    else r = v[WordWidth-1:0];
    return r;
  endfunction

endpackage

[rtl/core/srvb_ram.sv]
// ----------------------------------------------------------------------------
// srvb_ram: generic single-port synchronous RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module srvb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/core/schroeder_reverb.sv]
// ----------------------------------------------------------------------------
// schroeder_reverb: four comb lines into two allpass lines, dry/wet blend
// Sequenced over one shared line memory, one line per read/write pair.
// ----------------------------------------------------------------------------
// All six delay lines live in one single-port memory of 6 x 4096 words. Per
// sample each line is read in ST_READ, then computed and written back in
// ST_CALC, for all six lines in turn; then ST_MIX forms the blend, ST_DONE
// loads the output register once it is free and the machine returns to idle.
// After reset a clearing pass sweeps all 24576 words, one per cycle; after a
// length write the same full sweep runs but zeroes only the rewritten line.
// No sample is accepted during a sweep. Write configuration only while no
// sample is in flight. The result sits in an output register and the next
// sample may be taken while it waits.
module schroeder_reverb (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srvb_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [srvb_pkg::CfgWidth-1:0]        cfg_data_i,
  input  logic                                 sample_in_valid_i,
  output logic                                 sample_in_ready_o,
  input  logic signed [srvb_pkg::SampleWidth-1:0] sample_in_i,
  output logic                                 sample_out_valid_o,
  input  logic                                 sample_out_ready_i,
  output logic signed [srvb_pkg::SampleWidth-1:0] sample_out_o
);
  import srvb_pkg::*;

  localparam int unsigned MemDepth = LineCount * LineDepth;
  localparam int unsigned AddrWidth = $clog2(MemDepth);

  state_e state_q, state_d;

  logic [15:0]               gain_q;
  logic [CfgWidth-1:0]       mix_q;
  logic [LenWidth-1:0]       len_q [LineCount];
  logic [PosWidth-1:0]       pos_q [LineCount];
  logic [AddrWidth-1:0]      clr_q;
  logic [LineCount-1:0]      clr_pend_q;
  logic [LineCount-1:0]      clr_mask_q;
  logic [LineWidth-1:0]      line_q;
  logic signed [SampleWidth-1:0] x_q;
  logic signed [WordWidth+2:0] sum_q;
  logic signed [WordWidth-1:0] wet_q;
  logic signed [SampleWidth-1:0] out_q;
  logic                      out_valid_q;

  logic                      we;
  logic [AddrWidth-1:0]      addr;
  logic signed [WordWidth-1:0] wdata, rdata;

  srvb_ram #(.Width(WordWidth), .Depth(MemDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic in_acc, out_acc, cfg_len, load_out;
  logic [LineWidth-1:0] cfg_line;
  logic [LineCount-1:0] clr_set;
  assign in_acc  = sample_in_valid_i && sample_in_ready_o;
  assign out_acc = sample_out_valid_o && sample_out_ready_i;
  assign cfg_len = cfg_we_i && (cfg_idx_i >= REG_COMB0) && (cfg_idx_i <= REG_AP1);
  assign cfg_line = LineWidth'(cfg_idx_i - REG_COMB0);
  assign clr_set = cfg_len ? (LineCount'(1) << cfg_line) : '0;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_acc);
  assign sample_in_ready_o = (state_q == ST_IDLE) && (clr_pend_q == '0);
  assign sample_out_valid_o = out_valid_q;
  assign sample_out_o = out_q;

  // current line position, wrapped
  logic [PosWidth-1:0] cur_pos, nxt_pos;
  logic [LenWidth-1:0] cur_len;
  logic [LenWidth-1:0] pos_inc;
  assign cur_len = len_q[line_q];
  assign cur_pos = ({1'b0, pos_q[line_q]} >= cur_len) ? '0 : pos_q[line_q];
  assign pos_inc = {1'b0, cur_pos} + 1'b1;
  assign nxt_pos = (pos_inc >= cur_len) ? '0 : pos_inc[PosWidth-1:0];

  // per-line arithmetic
  logic signed [47:0] prod, comb_w, ap_w, ap_y;
  logic signed [WordWidth-1:0] x_ext;
  assign x_ext  = WordWidth'(x_q);
  assign prod   = 48'(rdata) * $signed({1'b0, gain_q});
  assign comb_w = 48'(x_ext) + (prod >>> 16);
  assign ap_w   = 48'(wet_q) + 48'(rdata >>> 1);
  assign ap_y   = 48'(rdata) - 48'(wet_q);

  logic is_comb;
  assign is_comb = line_q < LineWidth'(CombCount);

  always_comb begin
    we = 1'b0;
    addr = {line_q, cur_pos};
    wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        // only lines marked for clearing are zeroed
        we = clr_mask_q[clr_q[AddrWidth-1 -: LineWidth]];
        addr = clr_q;
      end
      ST_CALC: begin
        we = 1'b1;
        wdata = is_comb ? sat_word(comb_w) : sat_word(ap_w);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AddrWidth'(MemDepth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (clr_pend_q != '0) state_d = ST_CLEAR;
        else if (in_acc) state_d = ST_READ;
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = (line_q == LineWidth'(LineCount - 1)) ? ST_MIX : ST_READ;
      ST_MIX:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // blend
  logic [16:0] m;
  logic signed [47:0] blend, blend_sh;
  logic signed [SampleWidth-1:0] blend_sat;
  assign m = (mix_q > 17'd65536) ? 17'd65536 : mix_q;
  assign blend = 48'(x_q) * $signed({1'b0, 17'd65536 - m}) + 48'(wet_q) * $signed({1'b0, m});
  assign blend_sh = blend >>> 16;
  always_comb begin
    if (blend_sh > 48'sd32767) blend_sat = 16'sh7fff;
    else if (blend_sh < -48'sd32768) blend_sat = 16'sh8000;
    else blend_sat = blend_sh[SampleWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      clr_pend_q <= '0;
      clr_mask_q <= '1;
      line_q <= '0;
      gain_q <= 16'd55050;
      mix_q <= 17'd19661;
      x_q <= '0;
      sum_q <= '0;
      wet_q <= '0;
      out_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LineCount; i++) begin
        len_q[i] <= default_len(LineWidth'(i));
        pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (state_q == ST_IDLE && clr_pend_q != '0) begin
        clr_mask_q <= clr_pend_q;
        clr_pend_q <= clr_set;
      end else begin
        clr_pend_q <= clr_pend_q | clr_set;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FEEDBACK: gain_q <= cfg_data_i[15:0];
          REG_MIX:      mix_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_len) begin
          // the sweep zeroes only the rewritten line
          len_q[cfg_line] <= fit_len(cfg_data_i[LenWidth-1:0]);
          pos_q[cfg_line] <= '0;
        end
      end
      if (in_acc) begin
        x_q <= sample_in_i;
        line_q <= '0;
        sum_q <= '0;
      end
      if (state_q == ST_CALC) begin
        pos_q[line_q] <= nxt_pos;
        line_q <= line_q + 1'b1;
        if (is_comb) begin
          sum_q <= sum_q + (WordWidth+3)'(rdata);
          if (line_q == LineWidth'(CombCount - 1))
            wet_q <= sat_word(48'((sum_q + (WordWidth+3)'(rdata)) >>> 2));
        end else begin
          wet_q <= sat_word(ap_y);
        end
      end
      if (load_out) out_q <= blend_sat;
      out_valid_q <= load_out ? 1'b1 : (out_acc ? 1'b0 : out_valid_q);
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !sample_in_ready_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_out_valid_o && !sample_out_ready_i) |=> $stable(sample_out_o))
    else $error("output word changed while stalled");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !we) else $error("memory write while idle");
`endif

endmodule
